// ===== hw/rtl/path_canonicalizer_top_macros.svh =====
// Assertion macros for the path canonicalizer.
`ifndef PATH_CANONICALIZER_TOP_MACROS_SVH
`define PATH_CANONICALIZER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PC_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path canonicalizer: same-cycle check failed");
`define PC_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("path canonicalizer: next-cycle check failed");
`else
`define PC_ASSERT_SAME(name, clk, rst, ante, cons)
`define PC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/pcanon_pkg.sv =====
package pcanon_pkg;

  localparam int PATH_MAX_DEF = 255;
  localparam int NAME_MAX_DEF = 63;

  localparam int BUF_AW    = 8;
  localparam int BUF_DEPTH = 1 << BUF_AW;

  localparam logic [7:0] SLASH_CHAR = 8'h2F;
  localparam logic [7:0] DOT_CHAR   = 8'h2E;

  localparam logic OP_PATH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_ABS  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  localparam logic [1:0] DOT_EMPTY = 2'd0;
  localparam logic [1:0] DOT_ONE   = 2'd1;
  localparam logic [1:0] DOT_TWO   = 2'd2;
  localparam logic [1:0] DOT_NAME  = 2'd3;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_byte;
    logic       last;
    logic [7:0] read_index;
  } req_t;

  typedef struct packed {
    logic       done_res;
    logic [1:0] status;
    logic [7:0] out_length;
    logic [7:0] read_byte;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic start;
    logic wr_slash;
    logic char_act;
    logic clr_comp;
    logic set_err2;
    logic add_len;
    logic walk_rd;
    logic dec_len;
    logic rd_item;
    logic term;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic op_read;
    logic at_start;
    logic err_zero;
    logic c_zero;
    logic c_slash;
    logic ends;
    logic comp_zero;
    logic len_gt1;
    logic dot_one;
    logic dot_two;
    logic too_long;
    logic rd_slash;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/pcanon_ctrl.sv =====
module pcanon_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  pcanon_pkg::dp_sts_t sts,
  output pcanon_pkg::dp_cmd_t cmd
);
  import pcanon_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_CHAR  = 4'd3;
  localparam logic [3:0] S_ENDC  = 4'd4;
  localparam logic [3:0] S_WRD   = 4'd5;
  localparam logic [3:0] S_WCK   = 4'd6;
  localparam logic [3:0] S_TERM  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [3:0] post;
  logic       do_char;

  assign req_stall = (state != S_IDLE);
  // after a component closes: terminate the path or report
  assign post = sts.ends ? S_TERM : S_OUT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    do_char    = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.op_read) begin
          cmd.rd_item = 1'b1;
          state_next  = S_OUT;
        end else if (sts.at_start) begin
          cmd.start  = 1'b1;
          state_next = sts.ends ? S_ENDC : S_OUT;
        end else if (sts.err_zero && !sts.c_zero) begin
          if (sts.c_slash) begin
            state_next = S_ENDC;
          end else if (sts.comp_zero && sts.len_gt1) begin
            cmd.wr_slash = 1'b1;
            state_next   = S_CHAR;
          end else begin
            do_char = 1'b1;
          end
        end else begin
          state_next = sts.ends ? S_ENDC : S_OUT;
        end
      end
      S_CHAR: begin
        do_char = 1'b1;
      end
      S_ENDC: begin
        if (!sts.err_zero) begin
          state_next = S_OUT;
        end else if (sts.comp_zero || sts.dot_one) begin
          cmd.clr_comp = 1'b1;
          state_next   = post;
        end else if (sts.dot_two) begin
          state_next = S_WRD;
        end else if (sts.too_long) begin
          cmd.set_err2 = 1'b1;
          cmd.clr_comp = 1'b1;
          state_next   = post;
        end else begin
          cmd.add_len  = 1'b1;
          cmd.clr_comp = 1'b1;
          state_next   = post;
        end
      end
      S_WRD: begin
        if (!sts.len_gt1) begin
          cmd.clr_comp = 1'b1;
          state_next   = post;
        end else begin
          cmd.walk_rd = 1'b1;
          state_next  = S_WCK;
        end
      end
      S_WCK: begin
        cmd.dec_len = 1'b1;
        if (sts.rd_slash) begin
          cmd.clr_comp = 1'b1;
          state_next   = post;
        end else begin
          state_next = S_WRD;
        end
      end
      S_TERM: begin
        cmd.term   = sts.err_zero;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (do_char) begin
      cmd.char_act = 1'b1;
      if (sts.ends) begin
        state_next = S_ENDC;
      end else if (sts.out_free) begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/pcanon_dp.sv =====
module pcanon_dp #(
  parameter int PATH_MAX = pcanon_pkg::PATH_MAX_DEF,
  parameter int NAME_MAX = pcanon_pkg::NAME_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pcanon_pkg::req_t    req_word,
  input  pcanon_pkg::dp_cmd_t cmd,
  output pcanon_pkg::dp_sts_t sts,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output pcanon_pkg::rsp_t    rsp_word
);
  import pcanon_pkg::*;

  localparam int LEN_W  = $clog2(PATH_MAX + 1);
  localparam int CL_W   = $clog2(NAME_MAX + 2);
  localparam int AW_RAW = ((LEN_W > CL_W) ? LEN_W : CL_W) + 2;
  localparam int AW     = (AW_RAW > BUF_AW + 1) ? AW_RAW : BUF_AW + 1;

  logic [LEN_W-1:0] len;
  logic [CL_W-1:0]  comp;
  logic [1:0]       dot;
  logic [1:0]       err;
  logic             at_start;

  req_t             item;
  logic [7:0]       mem [BUF_DEPTH];
  logic [7:0]       rdata;
  logic             rd_oob;

  logic [AW-1:0]    len_w;
  logic [AW-1:0]    comp_w;
  logic [AW-1:0]    char_addr;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [7:0]       wdata;
  logic             wen;
  logic             ren;
  logic             len_gt1;
  logic             ends;
  logic [1:0]       dot_char;

  assign len_w     = AW'(len);
  assign comp_w    = AW'(comp);
  assign len_gt1   = (len > LEN_W'(1));
  assign char_addr = len_w + AW'(len_gt1) + comp_w;
  assign ends      = (item.operation == OP_PATH) && ((item.char_byte == 8'd0) || item.last);

  always_comb begin
    if (comp == '0) begin
      dot_char = (item.char_byte == DOT_CHAR) ? DOT_ONE : DOT_NAME;
    end else if ((dot == DOT_ONE) && (item.char_byte == DOT_CHAR)) begin
      dot_char = DOT_TWO;
    end else begin
      dot_char = DOT_NAME;
    end
  end

  always_comb begin
    waddr = '0;
    wdata = 8'd0;
    if (cmd.start) begin
      waddr = '0;
      wdata = SLASH_CHAR;
    end else if (cmd.wr_slash) begin
      waddr = len_w;
      wdata = SLASH_CHAR;
    end else if (cmd.char_act) begin
      waddr = char_addr;
      wdata = item.char_byte;
    end else if (cmd.term) begin
      waddr = len_w;
      wdata = 8'd0;
    end
  end

  // positions past the buffer are dropped on write; a read past it never counts as a slash
  assign wen = (cmd.start || cmd.wr_slash || cmd.char_act || cmd.term) &&
               (waddr[AW-1:BUF_AW] == '0);
  assign raddr = cmd.rd_item ? AW'(item.read_index) : (len_w - AW'(1));
  assign ren   = cmd.rd_item || cmd.walk_rd;

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr[BUF_AW-1:0]] <= wdata;
    end
    if (ren) begin
      rdata  <= mem[raddr[BUF_AW-1:0]];
      rd_oob <= (raddr[AW-1:BUF_AW] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req_word;
    end
    if (cmd.emit) begin
      rsp_word.done_res   <= ends;
      rsp_word.status     <= err;
      rsp_word.out_length <= 8'(len);
      rsp_word.read_byte  <= (item.operation == OP_READ) ? rdata : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= LEN_W'(1);
      comp      <= '0;
      dot       <= DOT_EMPTY;
      err       <= ST_OK;
      at_start  <= 1'b1;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        len      <= LEN_W'(1);
        comp     <= '0;
        dot      <= DOT_EMPTY;
        err      <= (item.char_byte == SLASH_CHAR) ? ST_OK : ST_NOT_ABS;
        at_start <= 1'b0;
      end
      if (cmd.char_act) begin
        dot <= dot_char;
        if (comp <= CL_W'(NAME_MAX)) begin
          comp <= comp + CL_W'(1);
        end
      end
      if (cmd.clr_comp) begin
        comp <= '0;
        dot  <= DOT_EMPTY;
      end
      if (cmd.set_err2) begin
        err <= ST_TOO_LONG;
      end
      if (cmd.add_len) begin
        len <= LEN_W'(char_addr);
      end
      if (cmd.dec_len) begin
        len <= len - LEN_W'(1);
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
        if (ends) begin
          err      <= ST_OK;
          at_start <= 1'b1;
          comp     <= '0;
          dot      <= DOT_EMPTY;
        end
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign sts.op_read   = (item.operation == OP_READ);
  assign sts.at_start  = at_start;
  assign sts.err_zero  = (err == ST_OK);
  assign sts.c_zero    = (item.char_byte == 8'd0);
  assign sts.c_slash   = (item.char_byte == SLASH_CHAR);
  assign sts.ends      = ends;
  assign sts.comp_zero = (comp == '0);
  assign sts.len_gt1   = len_gt1;
  assign sts.dot_one   = (dot == DOT_ONE);
  assign sts.dot_two   = (dot == DOT_TWO);
  assign sts.too_long  = (comp > CL_W'(NAME_MAX)) ||
                         ((len_w + AW'(1) + comp_w) > AW'(PATH_MAX));
  assign sts.rd_slash  = (rdata == SLASH_CHAR) && !rd_oob;
  assign sts.out_free  = !rsp_valid || !rsp_stall;

endmodule

// ===== hw/rtl/path_canonicalizer_top.sv =====
// Accept to result: a name byte is written from decode, after a slash write if one goes in
// first; a read word or first byte goes to output; a slash byte or path end closes the
// component, a path end then writes the terminator; ".." walks back byte by byte
// through the single read port to a slash or root. One word in flight; the next is taken
// the cycle after the result loads. A stalled result holds the controller until it drains.
// Reset (rst, sync, active high): length one, errors clear, buffer undefined until written.
`include "path_canonicalizer_top_macros.svh"

module path_canonicalizer_top #(
  parameter int PATH_MAX = pcanon_pkg::PATH_MAX_DEF,
  parameter int NAME_MAX = pcanon_pkg::NAME_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  pcanon_pkg::req_t req_word,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output pcanon_pkg::rsp_t rsp_word
);
  import pcanon_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  pcanon_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcanon_dp #(
    .PATH_MAX (PATH_MAX),
    .NAME_MAX (NAME_MAX)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req_word  (req_word),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

  `PC_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `PC_ASSERT_SAME(a_emit_into_free_slot, clk, rst, cmd.emit, !rsp_valid || !rsp_stall)
  `PC_ASSERT_NEXT(a_slash_then_char, clk, rst, cmd.wr_slash, cmd.char_act)

endmodule
